// File: src/ile_pkg.sv
package ile_pkg;

    localparam int OP_W  = 3;
    localparam int POS_W = 11;
    localparam int VAL_W = 32;
    localparam int LEN_W = 11;
    localparam int ST_W  = 2;

    localparam logic [OP_W-1:0] OP_READ       = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_HEAD   = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_TAIL   = 3'd2;
    localparam logic [OP_W-1:0] OP_INS_POS    = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE     = 3'd4;

    localparam logic [ST_W-1:0] STATUS_DONE   = 2'd0;
    localparam logic [ST_W-1:0] STATUS_RANGE  = 2'd1;
    localparam logic [ST_W-1:0] STATUS_FULL   = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] item_value;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic signed [VAL_W-1:0] read_value;
        logic [LEN_W-1:0]        length;
    } t_rsp;

    typedef struct packed {
        logic            accept;
        logic            decode;
        logic            walk_dec;
        logic            walk;
        logic            ins_head;
        logic            ins_link;
        logic            ins_prev;
        logic            del_head;
        logic            del_vic;
        logic            del_unlink;
        logic            finish;
        logic [ST_W-1:0] status;
        logic            rd_from_mem;
        logic            rd_fail;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            pos_zero;
        logic            pos_gt_cnt;
        logic            pos_ge_cnt;
        logic            full;
        logic            steps_zero;
    } t_sts;

endpackage

// File: src/indexed_list_engine.sv
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+------------------------------------------
// request   | in        | start & !busy      | i_req : operation, position, item_value
// response  | out       | strobe, one cycle  | o_rsp : status, read_value, length
//
// a beat that is rejected at decode answers from the decode state through the registered
// strobe; a positional request answers after a walk whose length is set by the position,
// through the next-link memory, one entry per cycle over its read port
// reset is synchronous and needs no clearing pass: the free chain is tracked by a fill mark
// busy stays high from the accepting edge until the strobe cycle; the receiver cannot stall
module indexed_list_engine #(
    parameter int CAPACITY = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  ile_pkg::t_req i_req,
    output logic          busy,
    output logic          strobe,
    output ile_pkg::t_rsp o_rsp
);

    ile_pkg::t_cmd w_cmd;
    ile_pkg::t_sts w_sts;

    ile_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    ile_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_strobe (strobe),
        .o_rsp    (o_rsp)
    );

endmodule

// File: src/ile_ctrl.sv
module ile_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  ile_pkg::t_sts i_sts,
    output ile_pkg::t_cmd o_cmd,
    output logic          busy
);

    typedef enum logic [9:0] {
        S_IDLE       = 10'b00_0000_0001,
        S_DECODE     = 10'b00_0000_0010,
        S_WALK       = 10'b00_0000_0100,
        S_RD_DONE    = 10'b00_0000_1000,
        S_INS_HEAD   = 10'b00_0001_0000,
        S_INS_LINK   = 10'b00_0010_0000,
        S_INS_PREV   = 10'b00_0100_0000,
        S_DEL_HEAD   = 10'b00_1000_0000,
        S_DEL_VIC    = 10'b01_0000_0000,
        S_DEL_UNLINK = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                case (i_sts.op)
                    ile_pkg::OP_READ: begin
                        if (i_sts.pos_ge_cnt) begin
                            o_cmd.finish  = 1'b1;
                            o_cmd.status  = ile_pkg::STATUS_RANGE;
                            o_cmd.rd_fail = 1'b1;
                            n_state       = S_IDLE;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                    ile_pkg::OP_INS_HEAD, ile_pkg::OP_INS_TAIL, ile_pkg::OP_INS_POS: begin
                        if (i_sts.pos_gt_cnt) begin
                            o_cmd.finish = 1'b1;
                            o_cmd.status = ile_pkg::STATUS_RANGE;
                            n_state      = S_IDLE;
                        end else if (i_sts.full) begin
                            o_cmd.finish = 1'b1;
                            o_cmd.status = ile_pkg::STATUS_FULL;
                            n_state      = S_IDLE;
                        end else if (i_sts.pos_zero) begin
                            n_state = S_INS_HEAD;
                        end else begin
                            o_cmd.walk_dec = 1'b1;
                            n_state        = S_WALK;
                        end
                    end
                    ile_pkg::OP_DELETE: begin
                        if (i_sts.pos_ge_cnt) begin
                            o_cmd.finish = 1'b1;
                            o_cmd.status = ile_pkg::STATUS_RANGE;
                            n_state      = S_IDLE;
                        end else if (i_sts.pos_zero) begin
                            n_state = S_DEL_HEAD;
                        end else begin
                            o_cmd.walk_dec = 1'b1;
                            n_state        = S_WALK;
                        end
                    end
                    default: begin
                        o_cmd.finish = 1'b1;
                        o_cmd.status = ile_pkg::STATUS_DONE;
                        n_state      = S_IDLE;
                    end
                endcase
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.steps_zero) begin
                    case (i_sts.op)
                        ile_pkg::OP_READ:   n_state = S_RD_DONE;
                        ile_pkg::OP_DELETE: n_state = S_DEL_VIC;
                        default:            n_state = S_INS_LINK;
                    endcase
                end
            end
            S_RD_DONE: begin
                o_cmd.finish      = 1'b1;
                o_cmd.status      = ile_pkg::STATUS_DONE;
                o_cmd.rd_from_mem = 1'b1;
                n_state           = S_IDLE;
            end
            S_INS_HEAD: begin
                o_cmd.ins_head = 1'b1;
                o_cmd.finish   = 1'b1;
                o_cmd.status   = ile_pkg::STATUS_DONE;
                n_state        = S_IDLE;
            end
            S_INS_LINK: begin
                o_cmd.ins_link = 1'b1;
                n_state        = S_INS_PREV;
            end
            S_INS_PREV: begin
                o_cmd.ins_prev = 1'b1;
                o_cmd.finish   = 1'b1;
                o_cmd.status   = ile_pkg::STATUS_DONE;
                n_state        = S_IDLE;
            end
            S_DEL_HEAD: begin
                o_cmd.del_head = 1'b1;
                o_cmd.finish   = 1'b1;
                o_cmd.status   = ile_pkg::STATUS_DONE;
                n_state        = S_IDLE;
            end
            S_DEL_VIC: begin
                o_cmd.del_vic = 1'b1;
                n_state       = S_DEL_UNLINK;
            end
            S_DEL_UNLINK: begin
                o_cmd.del_unlink = 1'b1;
                o_cmd.finish     = 1'b1;
                o_cmd.status     = ile_pkg::STATUS_DONE;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/ile_dp.sv
module ile_dp #(
    parameter int CAPACITY = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ile_pkg::t_req i_req,
    input  ile_pkg::t_cmd i_cmd,
    output ile_pkg::t_sts o_sts,
    output logic          o_strobe,
    output ile_pkg::t_rsp o_rsp
);

    localparam int SW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;
    localparam int VW = ile_pkg::VAL_W;

    logic [VW-1:0] r_ev_mem [CAPACITY];
    logic [SW-1:0] r_nl_mem [CAPACITY];
    logic [SW-1:0] r_fl_mem [CAPACITY];
    logic [VW-1:0] r_ev_q;
    logic [SW-1:0] r_nl_q;
    logic [SW-1:0] r_fl_q;

    logic [ile_pkg::OP_W-1:0] r_op;
    logic [XW-1:0]            r_pos;
    logic [VW-1:0]            r_val;
    logic [XW-1:0]            r_steps;
    logic [SW-1:0]            r_cur;
    logic                     r_use_q;
    logic [SW-1:0]            r_vic;
    logic [SW-1:0]            r_first;
    logic [SW-1:0]            r_free_top;
    logic [CW-1:0]            r_hw;
    logic [CW-1:0]            r_count;
    logic                     r_strobe;
    ile_pkg::t_rsp            r_rsp;

    logic [SW-1:0] n_first;
    logic [SW-1:0] n_free_top;
    logic [CW-1:0] n_hw;
    logic [CW-1:0] n_count;

    logic [SW-1:0] w_cur;
    logic [XW-1:0] w_count_x;
    logic [XW-1:0] w_len_x;
    logic [CW-1:0] w_top_x;
    logic [CW-1:0] w_top_inc;
    logic [SW-1:0] w_pop_next;
    logic          w_top_used;
    logic          w_pop;
    logic          w_push;
    logic [SW-1:0] w_push_slot;

    logic          w_nl_we;
    logic [SW-1:0] w_nl_wa;
    logic [SW-1:0] w_nl_wd;
    logic          w_nl_re;
    logic [SW-1:0] w_nl_ra;
    logic          w_ev_we;
    logic          w_ev_re;

    assign w_cur     = r_use_q ? r_nl_q : r_cur;
    assign w_count_x = XW'(r_count);
    assign w_top_x   = CW'(r_free_top);
    assign w_top_inc = w_top_x + CW'(1);
    assign w_top_used = (w_top_x < r_hw);
    assign w_pop_next = w_top_used ? r_fl_q :
                        ((w_top_inc == CW'(CAPACITY)) ? '0 : w_top_inc[SW-1:0]);
    assign w_pop       = i_cmd.ins_head | i_cmd.ins_prev;
    assign w_push      = i_cmd.del_head | i_cmd.del_unlink;
    assign w_push_slot = i_cmd.del_head ? r_first : r_vic;

    assign o_sts.op         = r_op;
    assign o_sts.pos_zero   = (r_pos == '0);
    assign o_sts.pos_gt_cnt = (r_pos > w_count_x);
    assign o_sts.pos_ge_cnt = (r_pos >= w_count_x);
    assign o_sts.full       = (r_count == CW'(CAPACITY));
    assign o_sts.steps_zero = (r_steps == '0);

    always_comb begin
        w_nl_we = 1'b0;
        w_nl_wa = r_free_top;
        w_nl_wd = r_first;
        w_ev_we = i_cmd.ins_head | i_cmd.ins_link;
        w_ev_re = i_cmd.walk & o_sts.steps_zero;
        w_nl_re = i_cmd.decode | i_cmd.walk | i_cmd.del_vic;
        w_nl_ra = r_first;
        if (i_cmd.walk) begin
            w_nl_ra = w_cur;
        end else if (i_cmd.del_vic) begin
            w_nl_ra = r_nl_q;
        end
        if (i_cmd.ins_head) begin
            w_nl_we = 1'b1;
        end else if (i_cmd.ins_link) begin
            w_nl_we = 1'b1;
            w_nl_wd = r_nl_q;
        end else if (i_cmd.ins_prev) begin
            w_nl_we = 1'b1;
            w_nl_wa = r_cur;
            w_nl_wd = r_free_top;
        end else if (i_cmd.del_unlink) begin
            w_nl_we = 1'b1;
            w_nl_wa = r_cur;
            w_nl_wd = r_nl_q;
        end
    end

    always_comb begin
        n_first    = r_first;
        n_free_top = r_free_top;
        n_hw       = r_hw;
        n_count    = r_count;
        if (i_cmd.ins_head) begin
            n_first = r_free_top;
        end else if (i_cmd.del_head) begin
            n_first = r_nl_q;
        end
        if (w_pop) begin
            n_free_top = w_pop_next;
            n_count    = r_count + CW'(1);
            if (!w_top_used) begin
                n_hw = r_hw + CW'(1);
            end
        end else if (w_push) begin
            n_free_top = w_push_slot;
            n_count    = r_count - CW'(1);
        end
    end

    assign w_len_x = XW'(n_count);

    always_ff @(posedge i_clk) begin
        if (w_ev_we) begin
            r_ev_mem[r_free_top] <= r_val;
        end
        if (w_ev_re) begin
            r_ev_q <= r_ev_mem[w_cur];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_nl_we) begin
            r_nl_mem[w_nl_wa] <= w_nl_wd;
        end
        if (w_nl_re) begin
            r_nl_q <= r_nl_mem[w_nl_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fl_mem[w_push_slot] <= r_free_top;
        end
        if (i_cmd.decode) begin
            r_fl_q <= r_fl_mem[r_free_top];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first    <= '0;
            r_free_top <= '0;
            r_hw       <= '0;
            r_count    <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_first    <= n_first;
            r_free_top <= n_free_top;
            r_hw       <= n_hw;
            r_count    <= n_count;
            r_strobe   <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_req.operation;
            r_val <= i_req.item_value;
            case (i_req.operation)
                ile_pkg::OP_INS_HEAD: r_pos <= '0;
                ile_pkg::OP_INS_TAIL: r_pos <= w_count_x;
                default:              r_pos <= XW'(i_req.position);
            endcase
        end
        if (i_cmd.decode) begin
            r_cur   <= r_first;
            r_use_q <= 1'b0;
            r_steps <= i_cmd.walk_dec ? (r_pos - XW'(1)) : r_pos;
        end
        if (i_cmd.walk) begin
            r_cur <= w_cur;
            if (o_sts.steps_zero) begin
                r_use_q <= 1'b0;
            end else begin
                r_use_q <= 1'b1;
                r_steps <= r_steps - XW'(1);
            end
        end
        if (i_cmd.del_vic) begin
            r_vic <= r_nl_q;
        end
        if (i_cmd.finish) begin
            r_rsp.status <= i_cmd.status;
            r_rsp.length <= w_len_x[ile_pkg::LEN_W-1:0];
            if (i_cmd.rd_fail) begin
                r_rsp.read_value <= '1;
            end else if (i_cmd.rd_from_mem) begin
                r_rsp.read_value <= r_ev_q;
            end else begin
                r_rsp.read_value <= '0;
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule
